@@ rtl/pcrl_pkg.sv @@
// package for the per-client rate limit table
// types, command codes and sizing constants; no dependencies
package pcrl_pkg;

  localparam int unsigned TableEntries = 64;
  localparam int unsigned IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam int unsigned CntW = $clog2(TableEntries + 1);

  typedef enum logic [2:0] {
    CMD_RATE    = 3'd0,
    CMD_CONN    = 3'd1,
    CMD_BLOCK   = 3'd2,
    CMD_UNBLOCK = 3'd3,
    CMD_QUERY   = 3'd4,
    CMD_CLEAR   = 3'd5,
    CMD_RSVD6   = 3'd6,
    CMD_RSVD7   = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_LIMITED = 2'd1,
    ST_BLOCKED = 2'd2,
    ST_RSVD    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CFG_RATE  = 2'd0,
    CFG_BURST = 2'd1,
    CFG_CONN  = 2'd2,
    CFG_NONE  = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_WAIT,
    S_EXEC,
    S_OUT
  } fsm_e;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] client_addr;
    logic [31:0] now_seconds;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        op_failed;
    logic        ip_blocked;
    logic [31:0] rate_violations;
    logic [31:0] flood_events;
    logic [31:0] blocks_total;
  } rsp_t;

  typedef struct packed {
    logic [31:0] address;
    logic [31:0] requests;
    logic [31:0] window_start;
    logic [31:0] connections;
    logic [1:0]  state;
  } entry_t;

  function automatic logic [31:0] sat_inc(logic [31:0] v);
    return (v == '1) ? v : v + 32'd1;
  endfunction

endpackage

@@ rtl/pcrl_ram.sv @@
// single-port synchronous table memory, registered read
// depends on pcrl_pkg for the entry type
module pcrl_ram (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [pcrl_pkg::IdxW-1:0] addr_i,
  input  pcrl_pkg::entry_t    wdata_i,
  output pcrl_pkg::entry_t    rdata_o
);
  import pcrl_pkg::*;

  entry_t mem_q [TableEntries];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

@@ rtl/per_client_rate_limit_table.sv @@
// per-client rate limit table: top level with scan/modify control
// depends on pcrl_pkg and pcrl_ram
//
// usage: a request beat on req_* carries cmd, client_addr and now_seconds;
// one response beat on rsp_* follows for every request. cfg_* writes the
// rate, burst and connection limits by index 0..2; the user must do so only
// while the block is idle, as the block itself does not enforce it. the
// client table is a 64-entry single-port memory with valid bits held in
// flip-flops. a request scans the entries in order: a free entry is skipped,
// a valid one is read, then its registered data is compared. a hit stops
// the scan and one read-modify-write follows. one item is handled at a
// time. the response is held in an output register until taken; the next
// request may be accepted meanwhile, but its execute step waits until the
// earlier response has left. reset clears the valid bits, the totals and
// restores the default limits; no clearing pass is needed.
module per_client_rate_limit_table (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  output logic             req_ready_o,
  input  pcrl_pkg::req_t   req_data_i,
  output logic             rsp_valid_o,
  input  logic             rsp_ready_i,
  output pcrl_pkg::rsp_t   rsp_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [1:0]       cfg_index_i,
  input  logic [15:0]      cfg_data_i
);
  import pcrl_pkg::*;

  fsm_e state_q, state_d;
  req_t req_q;
  logic [TableEntries-1:0] valid_q, valid_d;
  logic [CntW-1:0] scan_q, scan_d;
  logic [IdxW-1:0] hit_q, hit_d;
  logic hit_found_q, hit_found_d;
  logic rd_pend_q, rd_pend_d;
  logic [15:0] rate_q, burst_q, maxc_q;
  logic [31:0] viol_q, viol_d, refu_q, refu_d, blk_q, blk_d;
  rsp_t rsp_q, rsp_d;
  logic rsp_valid_q, rsp_valid_d;

  logic ram_we;
  logic [IdxW-1:0] ram_addr;
  entry_t ram_wdata, ram_rdata;

  pcrl_ram u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  logic req_fire;
  logic rsp_free;
  logic [IdxW-1:0] free_idx;
  logic any_free;
  logic [IdxW-1:0] rd_idx_q;
  logic [IdxW-1:0] scan_idx;

  assign scan_idx = scan_q[IdxW-1:0];
  assign rsp_free = !rsp_valid_q || rsp_ready_i;
  assign req_ready_o = (state_q == S_IDLE);
  assign req_fire = req_valid_i && req_ready_o;
  assign cfg_ready_o = 1'b1;
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_data_o = rsp_q;

  // lowest free entry, priority encoder over the valid bits
  always_comb begin
    free_idx = '0;
    any_free = 1'b0;
    for (int i = TableEntries - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_idx = IdxW'(i);
        any_free = 1'b1;
      end
    end
  end

  entry_t cur, nxt;
  logic [1:0] st;
  logic failed;
  logic blocked;
  logic [31:0] reqs;

  always_comb begin
    state_d = state_q;
    valid_d = valid_q;
    scan_d = scan_q;
    hit_d = hit_q;
    hit_found_d = hit_found_q;
    rd_pend_d = 1'b0;
    viol_d = viol_q;
    refu_d = refu_q;
    blk_d = blk_q;
    rsp_d = rsp_q;
    rsp_valid_d = rsp_valid_q && !rsp_ready_i;
    ram_we = 1'b0;
    ram_addr = scan_idx;
    ram_wdata = ram_rdata;
    cur = ram_rdata;
    nxt = ram_rdata;
    st = ST_OK;
    failed = 1'b0;
    blocked = 1'b0;
    reqs = '0;

    unique case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          scan_d = '0;
          hit_found_d = 1'b0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        // compare the previous read, issue the next one
        if (rd_pend_q && ram_rdata.address == req_q.client_addr) begin
          hit_found_d = 1'b1;
          hit_d = rd_idx_q;
          ram_addr = rd_idx_q;
          state_d = S_EXEC;
        end else begin
          while_scan: begin
            if (scan_q == CntW'(TableEntries)) begin
              state_d = S_EXEC;
            end else begin
              if (valid_q[scan_idx]) begin
                ram_addr = scan_idx;
                rd_pend_d = 1'b1;
                state_d = S_WAIT;
              end
              scan_d = scan_q + CntW'(1);
            end
          end
        end
      end
      S_WAIT: begin
        rd_pend_d = 1'b1;
        ram_addr = rd_idx_q;
        state_d = S_SCAN;
      end
      S_EXEC: begin
        // keep the hit entry on the read port while the output is stalled
        ram_addr = hit_q;
        if (rsp_free) begin
          cur = ram_rdata;
          if (!hit_found_q) begin
            cur = '{address: req_q.client_addr, requests: '0, window_start: '0,
                    connections: '0, state: ST_OK};
          end
          nxt = cur;
          unique case (cmd_e'(req_q.cmd))
            CMD_RATE, CMD_CONN, CMD_BLOCK: begin
              if (hit_found_q || any_free) begin
                ram_we = 1'b1;
                ram_addr = hit_found_q ? hit_q : free_idx;
                if (!hit_found_q) valid_d[free_idx] = 1'b1;
                if (req_q.cmd == CMD_RATE) begin
                  reqs = (req_q.now_seconds != cur.window_start) ? 32'd1
                                                                 : sat_inc(cur.requests);
                  nxt.requests = reqs;
                  nxt.window_start = req_q.now_seconds;
                  if (reqs > {16'd0, rate_q}) begin
                    if (reqs > {16'd0, burst_q}) begin
                      st = ST_BLOCKED;
                      viol_d = sat_inc(viol_q);
                    end else begin
                      st = ST_LIMITED;
                    end
                  end
                  nxt.state = st;
                end else if (req_q.cmd == CMD_CONN) begin
                  if (cur.connections >= {16'd0, maxc_q}) begin
                    refu_d = sat_inc(refu_q);
                    st = ST_BLOCKED;
                  end else begin
                    nxt.connections = sat_inc(cur.connections);
                  end
                end else begin
                  nxt.state = ST_BLOCKED;
                  blk_d = sat_inc(blk_q);
                end
                blocked = (nxt.state == ST_BLOCKED);
              end else begin
                failed = (req_q.cmd == CMD_BLOCK);
              end
            end
            CMD_UNBLOCK: begin
              if (hit_found_q) begin
                ram_we = 1'b1;
                ram_addr = hit_q;
                nxt.state = ST_OK;
              end else begin
                failed = 1'b1;
              end
            end
            CMD_CLEAR: begin
              viol_d = '0;
              refu_d = '0;
              blk_d = '0;
              blocked = hit_found_q && (cur.state == ST_BLOCKED);
            end
            default: begin
              blocked = hit_found_q && (cur.state == ST_BLOCKED);
            end
          endcase
          ram_wdata = nxt;
          rsp_d = '{status: st, op_failed: failed, ip_blocked: blocked,
                    rate_violations: viol_d, flood_events: refu_d,
                    blocks_total: blk_d};
          rsp_valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // index of the entry whose read is in flight, plus the request, response and hit registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_SCAN && rd_pend_d) rd_idx_q <= scan_idx;
    if (req_fire) req_q <= req_data_i;
    rsp_q <= rsp_d;
    hit_q <= hit_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= '0;
      scan_q <= '0;
      hit_found_q <= 1'b0;
      rd_pend_q <= 1'b0;
      viol_q <= '0;
      refu_q <= '0;
      blk_q <= '0;
      rsp_valid_q <= 1'b0;
      rate_q <= 16'd100;
      burst_q <= 16'd200;
      maxc_q <= 16'd64;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      scan_q <= scan_d;
      hit_found_q <= hit_found_d;
      rd_pend_q <= rd_pend_d && (state_q == S_WAIT);
      viol_q <= viol_d;
      refu_q <= refu_d;
      blk_q <= blk_d;
      rsp_valid_q <= rsp_valid_d;
      if (cfg_valid_i) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_RATE:  rate_q <= cfg_data_i;
          CFG_BURST: burst_q <= cfg_data_i;
          CFG_CONN:  maxc_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

`ifndef NO_ASSERTIONS
  // a response beat only ever comes out of the execute step
  a_rsp_from_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> $past(state_q) == S_EXEC)
    else $error("response without execute");
  // a hit is never taken from an entry that is not valid
  a_hit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC && hit_found_q) |-> valid_q[hit_q])
    else $error("hit on invalid entry");
  // execute never overwrites a waiting response
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC && rsp_valid_q && !rsp_ready_i) |=> state_q == S_EXEC)
    else $error("response overrun");
`endif

endmodule
